### hw/rtl/ptc_pkg.sv
// Shared types and constants of the port traffic counter table.
// Item layouts, status and kind codes, controller states and the
// command and status groups between controller and datapath.
package ptc_pkg;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // most snapshot items one tick may report
    localparam int MAX_RESULTS = 32;
    localparam int REPORT_W    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_PACKET = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_DEL    = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_COUNTED  = 4'd0,
        ST_IGNORED  = 4'd1,
        ST_ADDED    = 4'd2,
        ST_PRESENT  = 4'd3,
        ST_FULL     = 4'd4,
        ST_REMOVED  = 4'd5,
        ST_NOTFOUND = 4'd6,
        ST_SNAPSHOT = 4'd7,
        ST_EMPTY    = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_UPDATE,
        S_REPLY,
        S_SCAN_RD,
        S_SCAN_WR
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  protocol;
        logic [15:0] port;
        logic [15:0] ip_length;
        logic        syn_flag;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  entry_protocol;
        logic [15:0] entry_port;
        logic [31:0] packets;
        logic [31:0] bytes;
        logic [31:0] connections;
        logic        last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_in;
        logic    ram_rd;
        logic    rd_scan;
        logic    wr_count;
        logic    insert;
        logic    remove;
        logic    scan_clr;
        logic    scan_adv;
        logic    wr_clear;
        logic    emit;
        logic    emit_snap;
        status_t code;
    } ptc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        kind_t kind;
        logic  proto_ok;
        logic  hit;
        logic  has_free;
        logic  scan_valid;
        logic  scan_last;
        logic  any_reported;
        logic  out_free;
    } ptc_stat_t;

endpackage

### hw/rtl/ptc_if.sv
// Valid/ready channel interfaces for input and result items.
// Standalone; field widths follow the item layouts in ptc_pkg.
interface ptc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  protocol;
    logic [15:0] port;
    logic [15:0] ip_length;
    logic        syn_flag;

    modport source (output valid, kind, protocol, port, ip_length, syn_flag, input ready);
    modport sink   (input valid, kind, protocol, port, ip_length, syn_flag, output ready);
endinterface

interface ptc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  entry_protocol;
    logic [15:0] entry_port;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [31:0] connections;
    logic        last;

    modport source (output valid, status, entry_protocol, entry_port, packets, bytes,
                    connections, last, input ready);
    modport sink   (input valid, status, entry_protocol, entry_port, packets, bytes,
                    connections, last, output ready);
endinterface

### hw/rtl/ptc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ptc_ctrl.sv
// Controller state machine of the port traffic counter table.
// Uses ptc_pkg; drives ptc_cmd_t to the datapath and reads ptc_stat_t back.
module ptc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               ready,
    input  ptc_pkg::ptc_stat_t stat,
    output ptc_pkg::ptc_cmd_t  cmd
);
    import ptc_pkg::*;

    state_t  state_reg, state_next;
    status_t reply_reg, reply_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reply_reg <= ST_COUNTED;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd        = '0;
        cmd.code   = reply_reg;
        ready      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_LOOK;
                end
            end

            S_LOOK:
            begin
                state_next = S_REPLY;
                case (stat.kind)
                    KIND_PACKET:
                    begin
                        if (stat.proto_ok && stat.hit)
                        begin
                            cmd.ram_rd = 1'b1;
                            state_next = S_UPDATE;
                        end
                        else
                        begin
                            reply_next = ST_IGNORED;
                        end
                    end
                    KIND_ADD:
                    begin
                        if (stat.hit)
                        begin
                            reply_next = ST_PRESENT;
                        end
                        else if (stat.has_free)
                        begin
                            cmd.insert = 1'b1;
                            reply_next = ST_ADDED;
                        end
                        else
                        begin
                            reply_next = ST_FULL;
                        end
                    end
                    KIND_DEL:
                    begin
                        if (stat.hit)
                        begin
                            cmd.remove = 1'b1;
                            reply_next = ST_REMOVED;
                        end
                        else
                        begin
                            reply_next = ST_NOTFOUND;
                        end
                    end
                    KIND_TICK:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.wr_count = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.code     = ST_COUNTED;
                    state_next   = S_IDLE;
                end
            end

            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SCAN_RD:
            begin
                cmd.ram_rd  = 1'b1;
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_WR;
            end

            S_SCAN_WR:
            begin
                if (!stat.scan_valid || stat.out_free)
                begin
                    cmd.wr_clear  = 1'b1;
                    cmd.emit      = stat.scan_valid;
                    cmd.emit_snap = stat.scan_valid;
                    if (stat.scan_last)
                    begin
                        if (!stat.scan_valid && !stat.any_reported)
                        begin
                            reply_next = ST_EMPTY;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.scan_adv = 1'b1;
                        state_next   = S_SCAN_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ptc_dp.sv
// Datapath of the port traffic counter table: key table with match logic,
// counter memory, saturating adders, tick scan and result register.
// Uses ptc_pkg and ptc_ram.
module ptc_dp #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ptc_pkg::in_item_t  in_item,
    input  logic               out_ready,
    output logic               out_valid,
    output ptc_pkg::out_item_t out_item,
    input  ptc_pkg::ptc_cmd_t  cmd,
    output ptc_pkg::ptc_stat_t stat
);
    import ptc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    in_item_t            in_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [7:0]          key_proto_reg [ENTRIES];
    logic [15:0]         key_port_reg  [ENTRIES];
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [REPORT_W-1:0] rep_cnt_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [ENTRIES-1:0]  match;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    free_idx;
    logic                above_any;
    logic                scan_valid;
    logic                snap_last;
    logic                out_free;

    logic                          ram_wr_en;
    logic [IDX_W-1:0]              ram_wr_addr;
    logic [2:0][COUNT_BITS-1:0]    ram_wr_data;
    logic [IDX_W-1:0]              ram_rd_addr;
    logic [2:0][COUNT_BITS-1:0]    cnt;
    logic [2:0][COUNT_BITS-1:0]    inc;
    logic [2:0][COUNT_BITS-1:0]    cnt_upd;
    logic [2:0][31:0]              snap;
    out_item_t                     result;

    // Parallel key compare and lowest-index encoders
    always_comb
    begin
        hit_idx   = '0;
        free_idx  = '0;
        above_any = 1'b0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            match[e] = valid_reg[e] && (key_proto_reg[e] == in_reg.protocol)
                       && (key_port_reg[e] == in_reg.port);
            if (valid_reg[e] && (IDX_W'(e) > scan_idx_reg))
            begin
                above_any = 1'b1;
            end
        end
        for (int e = ENTRIES - 1; e >= 0; e--)
        begin
            if (match[e])
            begin
                hit_idx = IDX_W'(e);
            end
            if (!valid_reg[e])
            begin
                free_idx = IDX_W'(e);
            end
        end
    end

    assign scan_valid = valid_reg[scan_idx_reg] && (rep_cnt_reg < REPORT_W'(MAX_RESULTS));
    assign snap_last  = (rep_cnt_reg == REPORT_W'(MAX_RESULTS - 1)) || !above_any;
    assign out_free   = !out_valid_reg || out_ready;

    assign stat.kind         = in_reg.kind;
    assign stat.proto_ok     = (in_reg.protocol == PROTO_TCP)
                               || (in_reg.protocol == PROTO_UDP);
    assign stat.hit          = |match;
    assign stat.has_free     = ~&valid_reg;
    assign stat.scan_valid   = scan_valid;
    assign stat.scan_last    = (scan_idx_reg == IDX_W'(ENTRIES - 1));
    assign stat.any_reported = (rep_cnt_reg != '0);
    assign stat.out_free     = out_free;

    // Counter memory: packets, bytes, connections side by side
    ptc_ram #(
        .WIDTH (3 * COUNT_BITS),
        .DEPTH (ENTRIES)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (cnt)
    );

    assign ram_rd_addr = cmd.rd_scan ? scan_idx_reg : hit_idx;
    assign ram_wr_en   = cmd.wr_count || cmd.insert || cmd.wr_clear;

    always_comb
    begin
        ram_wr_addr = scan_idx_reg;
        ram_wr_data = '0;
        if (cmd.wr_count)
        begin
            ram_wr_addr = hit_idx;
            ram_wr_data = cnt_upd;
        end
        else if (cmd.insert)
        begin
            ram_wr_addr = free_idx;
        end
    end

    assign inc[0] = COUNT_BITS'(1);
    assign inc[1] = COUNT_BITS'(in_reg.ip_length);
    assign inc[2] = COUNT_BITS'(in_reg.syn_flag && (in_reg.protocol == PROTO_TCP));

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [COUNT_BITS:0] sum;

        // saturate on carry out
        assign sum        = {1'b0, cnt[k]} + {1'b0, inc[k]};
        assign cnt_upd[k] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

        if (COUNT_BITS > 32)
        begin : g_clip
            assign snap[k] = (|cnt[k][COUNT_BITS-1:32]) ? '1 : cnt[k][31:0];
        end
        else
        begin : g_ext
            assign snap[k] = 32'(cnt[k]);
        end
    end

    always_comb
    begin
        result        = '0;
        result.status = cmd.code;
        result.last   = 1'b1;
        if (cmd.emit_snap)
        begin
            result.status         = ST_SNAPSHOT;
            result.entry_protocol = key_proto_reg[scan_idx_reg];
            result.entry_port     = key_port_reg[scan_idx_reg];
            result.packets        = snap[0];
            result.bytes          = snap[1];
            result.connections    = snap[2];
            result.last           = snap_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            rep_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            else if (cmd.remove)
            begin
                valid_reg[hit_idx] <= 1'b0;
            end

            if (cmd.scan_clr)
            begin
                scan_idx_reg <= '0;
                rep_cnt_reg  <= '0;
            end
            else
            begin
                if (cmd.scan_adv)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (cmd.emit_snap)
                begin
                    rep_cnt_reg <= rep_cnt_reg + 1'b1;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_item;
        end
        if (cmd.insert)
        begin
            key_proto_reg[free_idx] <= in_reg.protocol;
            key_port_reg[free_idx]  <= in_reg.port;
        end
        if (cmd.emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

### hw/rtl/port_traffic_counter_table.sv
// Top level of the port traffic counter table: controller, datapath and
// channel hookup. Uses ptc_pkg, ptc_if, ptc_ctrl, ptc_dp (and ptc_ram).
//
//   channel | dir | payload                                          | moves
//   --------+-----+--------------------------------------------------+---------------
//   in_ch   | in  | kind, protocol, port, ip_length, syn_flag        | one item
//   out_ch  | out | status, entry_protocol, entry_port, packets,     | one result item
//           |     | bytes, connections, last                         |
//
// Sequence: one item at a time. Packet, add and delete items pass S_IDLE
// (capture), S_LOOK (key match) and S_UPDATE or S_REPLY (counter update or
// reply); the result is loaded once the output register is free, and the next
// item is taken back in S_IDLE. A tick steps S_SCAN_RD and S_SCAN_WR per slot
// (then S_REPLY when no slot is valid), waits on output stalls, and reads and
// clears the counter memory one slot at a time through its single read port.
// Reset: clears the slot valid bits and all control state; no clearing pass.
// Stalls: a finished result sits in the output register; a new item is taken
// while it waits, and work stalls only when the next result has nowhere to go.
module port_traffic_counter_table #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ptc_in_if.sink    in_ch,
    ptc_out_if.source out_ch
);
    import ptc_pkg::*;

    in_item_t  in_item;
    out_item_t out_item;
    ptc_cmd_t  cmd;
    ptc_stat_t stat;

    // Gather the input fields into one item
    assign in_item.kind      = kind_t'(in_ch.kind);
    assign in_item.protocol  = in_ch.protocol;
    assign in_item.port      = in_ch.port;
    assign in_item.ip_length = in_ch.ip_length;
    assign in_item.syn_flag  = in_ch.syn_flag;

    // Sequencing: accept, look up, then update, reply or scan
    ptc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .ready    (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Key table, counter memory and result register
    ptc_dp #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Spread the result item over the output fields
    assign out_ch.status         = out_item.status;
    assign out_ch.entry_protocol = out_item.entry_protocol;
    assign out_ch.entry_port     = out_item.entry_port;
    assign out_ch.packets        = out_item.packets;
    assign out_ch.bytes          = out_item.bytes;
    assign out_ch.connections    = out_item.connections;
    assign out_ch.last           = out_item.last;

endmodule

### hw/rtl/ptc_checker.sv
// Port-level checks of the port traffic counter table, bound to the top.
// Uses ptc_pkg for the status codes.
module ptc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  status,
    input logic [7:0]  entry_protocol,
    input logic [15:0] entry_port,
    input logic [31:0] packets,
    input logic [31:0] bytes,
    input logic [31:0] connections,
    input logic        last
);
    import ptc_pkg::*;

    // hold a stalled result item unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last)
            && $stable(packets) && $stable(bytes) && $stable(connections))
        else $error("result item changed while stalled");

    // one item at a time: drop ready after an accepted item
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    // non-snapshot results are single, with zero entry fields
    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_SNAPSHOT) |-> last && (entry_protocol == '0)
            && (entry_port == '0) && (packets == '0) && (bytes == '0)
            && (connections == '0))
        else $error("plain result carries entry data or is not last");

    // every status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_EMPTY))
        else $error("undefined status code");

endmodule

bind port_traffic_counter_table ptc_checker u_ptc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .entry_protocol (out_ch.entry_protocol),
    .entry_port     (out_ch.entry_port),
    .packets        (out_ch.packets),
    .bytes          (out_ch.bytes),
    .connections    (out_ch.connections),
    .last           (out_ch.last)
);

### tb/ptc_table_checker.sv
// Checker for the port traffic counter table: keeps its own copy of the slot
// table, predicts the result items of each accepted input item and compares.
// Depends on ptc_pkg and the channel interfaces ptc_in_if and ptc_out_if.
module ptc_table_checker #(
    parameter int ENTRIES = 32
) (
    input  logic clk,
    input  logic rst_n,
    ptc_in_if    in_ch,
    ptc_out_if   out_ch,
    output int   errors,
    output int   pending
);
    import ptc_pkg::*;

    // Counters are as wide as the result fields, so a report needs no clipping.
    localparam logic [31:0] COUNT_MAX = '1;

    logic        slot_used  [ENTRIES];
    logic [7:0]  slot_proto [ENTRIES];
    logic [15:0] slot_port  [ENTRIES];
    logic [31:0] pkt_cnt    [ENTRIES];
    logic [31:0] byte_cnt   [ENTRIES];
    logic [31:0] conn_cnt   [ENTRIES];
    out_item_t   expected_q [$];

    function automatic logic [31:0] sat_add(logic [31:0] acc, logic [31:0] inc);
        logic [32:0] sum;
        sum = {1'b0, acc} + {1'b0, inc};
        return sum[32] ? COUNT_MAX : sum[31:0];
    endfunction

    function automatic int find_slot(logic [7:0] proto, logic [15:0] port);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_proto[i] == proto && slot_port[i] == port)
                return i;
        return -1;
    endfunction

    task automatic push_status(status_t code);
        out_item_t res;
        res        = '0;
        res.status = code;
        res.last   = 1'b1;
        expected_q.push_back(res);
    endtask

    task automatic predict_results(in_item_t item);
        int        hit;
        int        total;
        int        shown;
        out_item_t res;
        hit = find_slot(item.protocol, item.port);
        case (item.kind)
            KIND_PACKET:
            begin
                if ((item.protocol != PROTO_TCP && item.protocol != PROTO_UDP) || hit < 0)
                    push_status(ST_IGNORED);
                else
                begin
                    pkt_cnt[hit]  = sat_add(pkt_cnt[hit], 32'd1);
                    byte_cnt[hit] = sat_add(byte_cnt[hit], {16'd0, item.ip_length});
                    // SYN only counts on TCP
                    if (item.protocol == PROTO_TCP && item.syn_flag)
                        conn_cnt[hit] = sat_add(conn_cnt[hit], 32'd1);
                    push_status(ST_COUNTED);
                end
            end
            KIND_ADD:
            begin
                if (hit >= 0)
                    push_status(ST_PRESENT);
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!slot_used[i] && hit < 0)
                            hit = i;
                    if (hit < 0)
                        push_status(ST_FULL);
                    else
                    begin
                        slot_used[hit]  = 1'b1;
                        slot_proto[hit] = item.protocol;
                        slot_port[hit]  = item.port;
                        pkt_cnt[hit]    = '0;
                        byte_cnt[hit]   = '0;
                        conn_cnt[hit]   = '0;
                        push_status(ST_ADDED);
                    end
                end
            end
            KIND_DEL:
            begin
                if (hit < 0)
                    push_status(ST_NOTFOUND);
                else
                begin
                    slot_used[hit] = 1'b0;
                    push_status(ST_REMOVED);
                end
            end
            KIND_TICK:
            begin
                total = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i])
                        total++;
                if (total > MAX_RESULTS)
                    total = MAX_RESULTS;
                shown = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_used[i] && shown < total)
                    begin
                        res                = '0;
                        res.status         = ST_SNAPSHOT;
                        res.entry_protocol = slot_proto[i];
                        res.entry_port     = slot_port[i];
                        res.packets        = pkt_cnt[i];
                        res.bytes          = byte_cnt[i];
                        res.connections    = conn_cnt[i];
                        res.last           = (shown == total - 1);
                        expected_q.push_back(res);
                        shown++;
                    end
                    pkt_cnt[i]  = '0;
                    byte_cnt[i] = '0;
                    conn_cnt[i] = '0;
                end
                if (total == 0)
                    push_status(ST_EMPTY);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        in_item_t  item;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_used[i] = 1'b0;
            expected_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // a result leaves only after its item has been registered and looked up, so order here is free
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result item, status expected none, got %0d",
                             $time, out_ch.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("entry_protocol", want.entry_protocol, out_ch.entry_protocol);
                    check_field("entry_port", want.entry_port, out_ch.entry_port);
                    check_field("packets", want.packets, out_ch.packets);
                    check_field("bytes", want.bytes, out_ch.bytes);
                    check_field("connections", want.connections, out_ch.connections);
                    check_field("last", want.last, out_ch.last);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                item.kind      = kind_t'(in_ch.kind);
                item.protocol  = in_ch.protocol;
                item.port      = in_ch.port;
                item.ip_length = in_ch.ip_length;
                item.syn_flag  = in_ch.syn_flag;
                predict_results(item);
            end
            pending = expected_q.size();
        end
    end

endmodule

### tb/port_traffic_counter_table_tb.sv
// Top of the port traffic counter table testbench: clock, reset, item
// stimulus, result back-pressure, watchdog and verdict.
// Depends on ptc_pkg, ptc_if, the block itself and ptc_table_checker.
module port_traffic_counter_table_tb;
    import ptc_pkg::*;

    localparam int ENTRIES      = 32;
    localparam int KEYS         = 40;      // more keys than slots, so fills overflow
    localparam int RANDOM_ITEMS = 120;
    localparam int STALL_LIMIT  = 4000;    // cycles with no handshake before giving up

    logic        clk;
    logic        rst_n;
    int          errors;
    int          pending;
    int          items_sent;
    int          idle_cycles;
    bit          in_calm;
    bit          out_calm;
    logic [7:0]  key_proto [KEYS];
    logic [15:0] key_port  [KEYS];

    ptc_in_if  in_ch ();
    ptc_out_if out_ch ();

    port_traffic_counter_table #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (32)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ptc_table_checker #(
        .ENTRIES (ENTRIES)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: count cycles in which neither channel moves an item and
    // abandon the run once the count reaches the limit. A tick scan is the
    // longest legitimate silence, well under the limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic in_item_t make_item(kind_t kind, logic [7:0] proto, logic [15:0] port,
                                           logic [15:0] len = 16'd0, logic syn = 1'b0);
        in_item_t item;
        item.kind      = kind;
        item.protocol  = proto;
        item.port      = port;
        item.ip_length = len;
        item.syn_flag  = syn;
        return item;
    endfunction

    // Item on one of the pool keys, with random length and SYN.
    function automatic in_item_t pool_item(kind_t kind, int idx);
        return make_item(kind, key_proto[idx], key_port[idx], 16'($urandom), 1'($urandom));
    endfunction

    // Item with every field random; mostly misses the table.
    function automatic in_item_t noise_item(kind_t kind);
        return make_item(kind, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    // Offer one item. Call at a falling edge; return at the falling edge after
    // acceptance. Valid stays high between back-to-back items so it never gets
    // two updates in one step.
    task automatic send(in_item_t item);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= item.kind;
        in_ch.protocol  <= item.protocol;
        in_ch.port      <= item.port;
        in_ch.ip_length <= item.ip_length;
        in_ch.syn_flag  <= item.syn_flag;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Result side: hold ready low for a random stall before each item,
    // unless a calm stretch is in force.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = out_calm ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    initial
    begin
        int start_count;
        int choice;
        int pick;
        int base;
        bit first;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= KIND_PACKET;
        in_ch.protocol  <= 8'd0;
        in_ch.port      <= 16'd0;
        in_ch.ip_length <= 16'd0;
        in_ch.syn_flag  <= 1'b0;
        in_calm         = 1'b0;
        out_calm        = 1'b0;
        items_sent      = 0;

        // Key pool: mostly TCP and UDP, some other protocols. The low port bits
        // carry the index, so every key is distinct.
        for (int k = 0; k < KEYS; k++)
        begin
            pick = $urandom_range(0, 9);
            key_proto[k] = (pick < 4) ? PROTO_TCP : (pick < 8) ? PROTO_UDP : 8'($urandom);
            key_port[k]  = {10'($urandom), 6'(k)};
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty tick, extreme ports, adds of odd protocols,
        // duplicate add, counting with max and zero length, UDP SYN, misses,
        // lowest-free-slot reuse and deletes down to an empty table again.
        send(make_item(KIND_TICK, 8'd0, 16'd0));
        send(make_item(KIND_ADD, PROTO_TCP, 16'd0));
        send(make_item(KIND_ADD, PROTO_UDP, 16'hFFFF));
        send(make_item(KIND_ADD, 8'hFF, 16'd1234));
        send(make_item(KIND_ADD, 8'h00, 16'd80));
        send(make_item(KIND_ADD, PROTO_TCP, 16'd0));
        send(make_item(KIND_PACKET, PROTO_TCP, 16'd0, 16'hFFFF, 1'b1));
        send(make_item(KIND_PACKET, PROTO_TCP, 16'd0, 16'd0, 1'b0));
        send(make_item(KIND_PACKET, PROTO_UDP, 16'hFFFF, 16'd1500, 1'b1));
        send(make_item(KIND_PACKET, 8'hFF, 16'd1234, 16'd60, 1'b1));
        send(make_item(KIND_PACKET, PROTO_TCP, 16'd5, 16'd60, 1'b0));
        send(make_item(KIND_PACKET, PROTO_UDP, 16'd0, 16'd60, 1'b0));
        send(make_item(KIND_DEL, PROTO_TCP, 16'd9999));
        send(make_item(KIND_TICK, 8'd0, 16'd0));
        send(make_item(KIND_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send(make_item(KIND_DEL, 8'hFF, 16'd1234));
        send(make_item(KIND_ADD, PROTO_TCP, 16'd443));
        send(make_item(KIND_PACKET, PROTO_TCP, 16'd443, 16'd40, 1'b1));
        send(make_item(KIND_DEL, PROTO_TCP, 16'd0));
        send(make_item(KIND_PACKET, PROTO_TCP, 16'd0, 16'd40, 1'b1));
        send(make_item(KIND_TICK, 8'd0, 16'd0));
        send(make_item(KIND_DEL, PROTO_UDP, 16'hFFFF));
        send(make_item(KIND_DEL, 8'h00, 16'd80));
        send(make_item(KIND_DEL, PROTO_TCP, 16'd443));
        send(make_item(KIND_TICK, 8'd0, 16'd0));

        // Random part in phases, each closed by a tick. The first phase always
        // fills the table so later traffic finds plenty of live entries.
        start_count = items_sent;
        first       = 1'b1;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            choice   = first ? 0 : $urandom_range(0, 4);
            first    = 1'b0;
            case (choice)
                0:
                begin
                    // fill: more distinct adds than slots, so the table overflows
                    base = $urandom_range(0, KEYS - 1);
                    for (int j = 0; j < 36; j++)
                    begin
                        send(pool_item(KIND_ADD, (base + j) % KEYS));
                        if ($urandom_range(0, 3) == 0)
                            send(pool_item(KIND_PACKET, $urandom_range(0, KEYS - 1)));
                    end
                end
                1, 2:
                begin
                    // traffic: mostly packets on known keys, some noise and churn
                    repeat (20)
                    begin
                        pick = $urandom_range(0, 99);
                        base = $urandom_range(0, KEYS - 1);
                        if (pick < 65)
                            send(pool_item(KIND_PACKET, base));
                        else if (pick < 75)
                            send(noise_item(KIND_PACKET));
                        else if (pick < 85)
                            send(pool_item(KIND_ADD, base));
                        else if (pick < 95)
                            send(pool_item(KIND_DEL, base));
                        else
                            send(noise_item(kind_t'($urandom_range(0, 3))));
                    end
                end
                default:
                begin
                    // churn: adds and deletes, some of absent keys
                    repeat (16)
                    begin
                        pick = $urandom_range(0, 99);
                        base = $urandom_range(0, KEYS - 1);
                        if (pick < 40)
                            send(pool_item(KIND_DEL, base));
                        else if (pick < 75)
                            send(pool_item(KIND_ADD, base));
                        else if (pick < 90)
                            send(noise_item(KIND_DEL));
                        else
                            send(pool_item(KIND_PACKET, base));
                    end
                end
            endcase
            send(make_item(KIND_TICK, 8'($urandom), 16'($urandom)));
        end

        // Drain: hold off until every predicted item has arrived, then allow
        // a full tick scan's worth of cycles for anything stray.
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2 * ENTRIES + 10) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_if.sv
hw/rtl/ptc_ram.sv
hw/rtl/ptc_ctrl.sv
hw/rtl/ptc_dp.sv
hw/rtl/port_traffic_counter_table.sv
hw/rtl/ptc_checker.sv
tb/ptc_table_checker.sv
tb/port_traffic_counter_table_tb.sv
